@@ hdl/sgm_pkg.sv @@
// Shared constants, payload types and register codes of the Sobel gradient unit.
package sgm_pkg;

  // Line length bound handed to the top level as its default
  localparam int MAX_WIDTH_DEF = 1024;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 11;
  localparam int MAG_W  = 11;
  localparam int CSUM_W = 10;  // t + 2m + b of one column
  localparam int VD_W   = 9;   // b - t of one column, signed

  // Configuration registers
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam int FRAME_WIDTH_RST  = 512;
  localparam int FRAME_HEIGHT_RST = 512;
  localparam int MIN_DIM          = 3;
  localparam int MAX_HEIGHT       = 4096;

  // Result queue
  localparam int OUT_FIFO_DEPTH = 8;

  typedef logic [PIX_W-1:0] pixel_t;

  // One window column, top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // What a window cell hands on: its column and its two partial sums
  typedef struct packed {
    column_t                  pix;
    logic [CSUM_W-1:0]        col_sum;
    logic signed [VD_W-1:0]   vdiff;
  } cell_out_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [MAG_W-1:0]         magnitude;
    logic                     last_of_frame;
  } result_t;

endpackage

@@ hdl/sgm_if.sv @@
// Stream interfaces for the pixel input and the gradient result output.
interface sgm_pixel_if;
  logic                    valid;
  logic                    ready;
  logic [sgm_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sgm_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [sgm_pkg::GRAD_W-1:0] grad_x;
  logic signed [sgm_pkg::GRAD_W-1:0] grad_y;
  logic [sgm_pkg::MAG_W-1:0]         magnitude;
  logic                              last_of_frame;

  modport source (output valid, output grad_x, output grad_y, output magnitude,
                  output last_of_frame, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input magnitude,
                  input last_of_frame, output ready);
endinterface

@@ hdl/sgm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/sgm_cell.sv @@
// Window cell: holds one 3-pixel column, shifts it to its left neighbor, forms partial sums.
module sgm_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  sgm_pkg::column_t   col_in,
  output sgm_pkg::cell_out_t cell_out
);
  import sgm_pkg::*;

  column_t col_r;

  // Column register, loaded from the right neighbor on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  // Weighted column sum for grad_x, bottom minus top for grad_y
  always_comb begin
    cell_out.pix     = col_r;
    cell_out.col_sum = CSUM_W'(col_r.top) + CSUM_W'({col_r.mid, 1'b0}) + CSUM_W'(col_r.bot);
    cell_out.vdiff   = $signed({1'b0, col_r.bot}) - $signed({1'b0, col_r.top});
  end

endmodule

@@ hdl/sgm_out_fifo.sv @@
// Result queue between the gradient pipeline and the output handshake.
module sgm_out_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  sgm_pkg::result_t           push_data,
  input  logic                       pop_ready,
  output logic                       out_valid,
  output sgm_pkg::result_t           out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import sgm_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t        mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = out_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hdl/sobel_gradient_magnitude_unit.sv @@
// Sobel 3x3 gradient unit: a result for each interior pixel passes, after its input
// transaction, through line RAM read, window shift, gradient and magnitude into the result queue.
// Throughput is one pixel per cycle, set by the one-read/one-write line RAM and an
// 8-entry result queue whose free space gates in_stream.ready; the rate holds only while ready is high.
// Reset: frame 512x512 (width capped at MAX_WIDTH), position counters zero; the line RAM
// is not cleared, since rows 0 and 1 of every frame rewrite it before any read is used.
module sobel_gradient_magnitude_unit #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sgm_pixel_if.sink                        in_stream,
  sgm_result_if.source                     out_stream,
  input  logic                             cfg_wr_en,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sgm_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int QCW = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int WIDTH_LAST_RST =
    ((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST) - 1;
  localparam int HEIGHT_LAST_RST = FRAME_HEIGHT_RST - 1;

  // Frame geometry, kept as last column / last row after clamping
  logic [CW-1:0]    width_last_r;
  logic [ROW_W-1:0] height_last_r;
  logic [CW-1:0]    width_last_nxt;
  logic [ROW_W-1:0] height_last_nxt;
  logic [FW_W-1:0]  cfg_fw;
  logic [FH_W-1:0]  cfg_fh;
  logic             cfg_restart;

  // Position of the next pixel
  logic [CW-1:0]    col_count_r;
  logic [ROW_W-1:0] row_count_r;

  logic             in_acc;
  logic             in_emit;
  logic             in_last;

  // Stage 1: line RAM data arrives
  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_last_r;
  pixel_t           s1_pixel_r;
  logic [CW-1:0]    s1_col_r;
  logic [2*PIX_W-1:0] ram_rd_data;

  // Stage 2: window holds the new column
  logic             s2_valid_r;
  logic             s2_last_r;
  column_t          new_col;
  cell_out_t        cell_q [3];

  // Stage 3: gradients registered
  logic                     s3_valid_r;
  logic                     s3_last_r;
  logic signed [GRAD_W-1:0] s3_gx_r;
  logic signed [GRAD_W-1:0] s3_gy_r;
  logic signed [GRAD_W-1:0] gx_nxt;
  logic signed [GRAD_W-1:0] gy_nxt;
  logic [GRAD_W-1:0]        abs_gx;
  logic [GRAD_W-1:0]        abs_gy;
  result_t                  s3_result;

  // Result queue and credit
  result_t          q_data;
  logic             q_valid;
  logic [QCW-1:0]   q_count;
  logic [1:0]       pipe_pending;
  logic [QCW:0]     occupancy;
  logic [MAG_W-1:0] chk_mag;

  // ---------------------------------------------------------------------------
  // Configuration decode with clamping
  assign cfg_fw      = cfg_data[FW_W-1:0];
  assign cfg_fh      = cfg_data[FH_W-1:0];
  assign cfg_restart = cfg_wr_en &&
                       ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

  always_comb begin
    if (cfg_fw < FW_W'(MIN_DIM)) begin
      width_last_nxt = CW'(MIN_DIM - 1);
    end else if (int'(cfg_fw) > MAX_WIDTH) begin
      width_last_nxt = CW'(MAX_WIDTH - 1);
    end else begin
      width_last_nxt = CW'(cfg_fw - FW_W'(1));
    end
    if (cfg_fh < FH_W'(MIN_DIM)) begin
      height_last_nxt = ROW_W'(MIN_DIM - 1);
    end else if (int'(cfg_fh) > MAX_HEIGHT) begin
      height_last_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_last_nxt = ROW_W'(cfg_fh - FH_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= CW'(WIDTH_LAST_RST);
      height_last_r <= ROW_W'(HEIGHT_LAST_RST);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_last_r  <= width_last_nxt;
        CFG_FRAME_HEIGHT: height_last_r <= height_last_nxt;
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position counters
  assign in_acc  = in_stream.valid && in_stream.ready;
  assign in_emit = (row_count_r >= ROW_W'(2)) && (col_count_r >= CW'(2));
  assign in_last = (row_count_r == height_last_r) && (col_count_r == width_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (cfg_restart) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (in_acc) begin
      if (col_count_r == width_last_r) begin
        col_count_r <= '0;
        row_count_r <= (row_count_r == height_last_r) ? '0 : row_count_r + ROW_W'(1);
      end else begin
        col_count_r <= col_count_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line RAM: word is {row two up, row one up}; read on accept, rotate in the next cycle
  sgm_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data ({ram_rd_data[PIX_W-1:0], s1_pixel_r}),
    .rd_en   (in_acc),
    .rd_addr (col_count_r),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_emit_r  <= in_emit;
      s1_last_r  <= in_last;
      s1_pixel_r <= in_stream.pixel;
      s1_col_r   <= col_count_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Window: three cells, new column enters on the right
  assign new_col.top = ram_rd_data[2*PIX_W-1:PIX_W];
  assign new_col.mid = ram_rd_data[PIX_W-1:0];
  assign new_col.bot = s1_pixel_r;

  sgm_cell u_cell_right (
    .clk      (clk),
    .shift_en (s1_valid_r),
    .col_in   (new_col),
    .cell_out (cell_q[2])
  );

  sgm_cell u_cell_center (
    .clk      (clk),
    .shift_en (s1_valid_r),
    .col_in   (cell_q[2].pix),
    .cell_out (cell_q[1])
  );

  sgm_cell u_cell_left (
    .clk      (clk),
    .shift_en (s1_valid_r),
    .col_in   (cell_q[1].pix),
    .cell_out (cell_q[0])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Gradients from the cell partial sums
  always_comb begin
    gx_nxt = $signed({1'b0, cell_q[2].col_sum}) - $signed({1'b0, cell_q[0].col_sum});
    gy_nxt = $signed({{2{cell_q[0].vdiff[VD_W-1]}}, cell_q[0].vdiff})
           + $signed({cell_q[1].vdiff[VD_W-1], cell_q[1].vdiff, 1'b0})
           + $signed({{2{cell_q[2].vdiff[VD_W-1]}}, cell_q[2].vdiff});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      s3_gx_r   <= gx_nxt;
      s3_gy_r   <= gy_nxt;
      s3_last_r <= s2_last_r;
    end
  end

  // L1 magnitude, written into the queue
  assign abs_gx = s3_gx_r[GRAD_W-1] ? GRAD_W'(-s3_gx_r) : GRAD_W'(s3_gx_r);
  assign abs_gy = s3_gy_r[GRAD_W-1] ? GRAD_W'(-s3_gy_r) : GRAD_W'(s3_gy_r);

  always_comb begin
    s3_result.grad_x        = s3_gx_r;
    s3_result.grad_y        = s3_gy_r;
    s3_result.magnitude     = MAG_W'(abs_gx + abs_gy);
    s3_result.last_of_frame = s3_last_r;
  end

  sgm_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_valid_r),
    .push_data (s3_result),
    .pop_ready (out_stream.ready),
    .out_valid (q_valid),
    .out_data  (q_data),
    .count     (q_count)
  );

  assign out_stream.valid         = q_valid;
  assign out_stream.grad_x        = q_data.grad_x;
  assign out_stream.grad_y        = q_data.grad_y;
  assign out_stream.magnitude     = q_data.magnitude;
  assign out_stream.last_of_frame = q_data.last_of_frame;

  // Credit: results in flight plus queued must leave a free slot
  assign pipe_pending = 2'(s1_valid_r && s1_emit_r) + 2'(s2_valid_r) + 2'(s3_valid_r);
  assign occupancy    = (QCW + 1)'(q_count) + (QCW + 1)'(pipe_pending);
  assign in_stream.ready = (occupancy < (QCW + 1)'(OUT_FIFO_DEPTH));

  // ---------------------------------------------------------------------------
  // Assertions
  assign chk_mag = MAG_W'((out_stream.grad_x[GRAD_W-1] ? GRAD_W'(-out_stream.grad_x)
                                                       : GRAD_W'(out_stream.grad_x))
                        + (out_stream.grad_y[GRAD_W-1] ? GRAD_W'(-out_stream.grad_y)
                                                       : GRAD_W'(out_stream.grad_y)));

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (QCW + 1)'(OUT_FIFO_DEPTH))
    else $error("result queue credit exceeded");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_count_r <= width_last_r) && (row_count_r <= height_last_r))
    else $error("raster position outside frame");

  a_mag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid |-> (out_stream.magnitude == chk_mag))
    else $error("magnitude does not match gradients");

endmodule
